>>> sv/amrd_pkg.sv
// ----------------------------------------------------------------------------
// amrd_pkg
// Types and constants shared by the transform record decoder.
// ----------------------------------------------------------------------------
package amrd_pkg;

  localparam int unsigned TERM_W     = 31;
  localparam int unsigned NUM_TERMS  = 6;
  localparam int unsigned WIDTH_BITS = 5;
  localparam int unsigned TDATA_W    = ((NUM_TERMS * TERM_W + 7) / 8) * 8;

  localparam logic [TERM_W-1:0] ONE_FIXED = TERM_W'(65536);

  typedef enum logic [11:0] {
    PH_SFLAG = 12'b0000_0000_0001,
    PH_SN    = 12'b0000_0000_0010,
    PH_SX    = 12'b0000_0000_0100,
    PH_SY    = 12'b0000_0000_1000,
    PH_RFLAG = 12'b0000_0001_0000,
    PH_RN    = 12'b0000_0010_0000,
    PH_R0    = 12'b0000_0100_0000,
    PH_R1    = 12'b0000_1000_0000,
    PH_TN    = 12'b0001_0000_0000,
    PH_TX    = 12'b0010_0000_0000,
    PH_TY    = 12'b0100_0000_0000,
    PH_DONE  = 12'b1000_0000_0000
  } phase_e;

  // term order: scale_x, scale_y, skew_first, skew_second, shift_x, shift_y
  typedef logic [NUM_TERMS-1:0][TERM_W-1:0] terms_t;

  typedef struct packed {
    phase_e                phase;
    logic [WIDTH_BITS-1:0] fbits;
    logic [WIDTH_BITS-1:0] brem;
    logic [TERM_W-1:0]     acc;
    terms_t                terms;
    logic [1:0]            present;   // bit 0 scale, bit 1 rotate/skew
  } parse_st_t;

  typedef struct packed {
    logic [1:0] present;
    terms_t     terms;
  } result_t;

  localparam parse_st_t ST_RESET = '{
    phase:   PH_SFLAG,
    fbits:   '0,
    brem:    WIDTH_BITS'(1),
    acc:     '0,
    terms:   {TERM_W'(0), TERM_W'(0), TERM_W'(0), TERM_W'(0), ONE_FIXED, ONE_FIXED},
    present: '0
  };

  // sign-extend the low fbits bits of acc (acc holds no bits above them)
  function automatic logic [TERM_W-1:0] sext(input logic [TERM_W-1:0]     acc,
                                             input logic [WIDTH_BITS-1:0] fbits);
    logic [TERM_W-1:0] upper;
    logic              sgn;
    upper = {TERM_W{1'b1}} << fbits;
    sgn   = (fbits != '0) ? acc[fbits - WIDTH_BITS'(1)] : 1'b0;
    return sgn ? (acc | upper) : acc;
  endfunction

endpackage

>>> sv/amrd_bit.sv
// ----------------------------------------------------------------------------
// amrd_bit
// One bit step of the record parser: shifts a bit into the current field and
// moves to the next phase when the field is complete.
// ----------------------------------------------------------------------------
module amrd_bit import amrd_pkg::*; (
  input  parse_st_t st_i,
  input  logic      bit_i,
  output parse_st_t st_o,
  output logic      done_o
);

  logic [WIDTH_BITS-1:0] brem_cur;
  logic [WIDTH_BITS-1:0] brem_nxt;
  logic [WIDTH_BITS-1:0] fb_new;
  logic [TERM_W-1:0]     acc;
  logic [TERM_W-1:0]     val;

  assign brem_cur = (st_i.brem == '0) ? WIDTH_BITS'(1) : st_i.brem;
  assign brem_nxt = brem_cur - WIDTH_BITS'(1);
  assign acc      = {st_i.acc[TERM_W-2:0], bit_i};
  assign fb_new   = acc[WIDTH_BITS-1:0];
  assign val      = sext(acc, st_i.fbits);

  always_comb begin
    st_o      = st_i;
    done_o    = 1'b0;
    st_o.acc  = acc;
    st_o.brem = brem_nxt;
    if (brem_nxt == '0) begin
      st_o.acc = '0;
      case (st_i.phase)
        PH_RFLAG: begin
          if (bit_i) begin
            st_o.present[1] = 1'b1;
            st_o.phase      = PH_RN;
            st_o.brem       = WIDTH_BITS'(WIDTH_BITS);
          end else begin
            st_o.phase = PH_TN;
            st_o.brem  = WIDTH_BITS'(WIDTH_BITS);
          end
        end
        PH_SN: begin
          st_o.fbits = fb_new;
          if (fb_new != '0) begin
            st_o.phase = PH_SX;
            st_o.brem  = fb_new;
          end else begin
            st_o.terms[0] = '0;
            st_o.terms[1] = '0;
            st_o.phase    = PH_RFLAG;
            st_o.brem     = WIDTH_BITS'(1);
          end
        end
        PH_RN: begin
          st_o.fbits = fb_new;
          if (fb_new != '0) begin
            st_o.phase = PH_R0;
            st_o.brem  = fb_new;
          end else begin
            st_o.terms[2] = '0;
            st_o.terms[3] = '0;
            st_o.phase    = PH_TN;
            st_o.brem     = WIDTH_BITS'(WIDTH_BITS);
          end
        end
        PH_TN: begin
          st_o.fbits = fb_new;
          if (fb_new != '0) begin
            st_o.phase = PH_TX;
            st_o.brem  = fb_new;
          end else begin
            st_o.terms[4] = '0;
            st_o.terms[5] = '0;
            st_o.phase    = PH_DONE;
            done_o        = 1'b1;
          end
        end
        PH_SX: begin
          st_o.terms[0] = val;
          st_o.phase    = PH_SY;
          st_o.brem     = st_i.fbits;
        end
        PH_SY: begin
          st_o.terms[1] = val;
          st_o.phase    = PH_RFLAG;
          st_o.brem     = WIDTH_BITS'(1);
        end
        PH_R0: begin
          st_o.terms[2] = val;
          st_o.phase    = PH_R1;
          st_o.brem     = st_i.fbits;
        end
        PH_R1: begin
          st_o.terms[3] = val;
          st_o.phase    = PH_TN;
          st_o.brem     = WIDTH_BITS'(WIDTH_BITS);
        end
        PH_TX: begin
          st_o.terms[4] = val;
          st_o.phase    = PH_TY;
          st_o.brem     = st_i.fbits;
        end
        PH_TY: begin
          st_o.terms[5] = val;
          st_o.phase    = PH_DONE;
          done_o        = 1'b1;
        end
        default: begin
          // scale flag; stray codes parse as the scale flag too
          if (bit_i) begin
            st_o.present[0] = 1'b1;
            st_o.phase      = PH_SN;
            st_o.brem       = WIDTH_BITS'(WIDTH_BITS);
          end else begin
            st_o.phase = PH_RFLAG;
            st_o.brem  = WIDTH_BITS'(1);
          end
        end
      endcase
    end
  end

endmodule

>>> sv/amrd_core.sv
// ----------------------------------------------------------------------------
// amrd_core
// Parser state register and eight chained bit steps that consume one byte.
// ----------------------------------------------------------------------------
module amrd_core import amrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic [7:0] byte_i,
  input  logic      restart_i,
  output logic      done_o,
  output result_t   res_o
);

  parse_st_t st_q, st_d;
  parse_st_t chain [0:8];
  parse_st_t step  [0:7];
  logic      found [0:8];
  logic      hit   [0:7];

  assign chain[0] = restart_i ? ST_RESET : st_q;
  assign found[0] = 1'b0;

  for (genvar k = 0; k < 8; k++) begin : g_bit
    amrd_bit u_bit (
      .st_i   (chain[k]),
      .bit_i  (byte_i[7-k]),
      .st_o   (step[k]),
      .done_o (hit[k])
    );
    // bits after the end of a record are padding
    assign chain[k+1] = found[k] ? chain[k] : step[k];
    assign found[k+1] = found[k] | hit[k];
  end

  assign done_o        = found[8];
  assign res_o.terms   = chain[8].terms;
  assign res_o.present = chain[8].present;
  assign st_d          = found[8] ? ST_RESET : chain[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  a_no_done_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase != PH_DONE)
    else $error("parser state left in done phase");

  a_fresh_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && done_o |=> st_q.phase == PH_SFLAG && st_q.present == 2'b00
                       && st_q.acc == '0)
    else $error("record state not cleared after completion");

  a_flag_width_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_SFLAG || st_q.phase == PH_RFLAG) |-> st_q.brem == WIDTH_BITS'(1))
    else $error("flag phase with bit count other than one");

endmodule

>>> sv/affine_matrix_record_decoder.sv
// ----------------------------------------------------------------------------
// affine_matrix_record_decoder
// Decodes a byte stream of packed 2D transform records into matrix terms.
// ----------------------------------------------------------------------------
// Takes one byte per clock, back to back, while no held result stalls it. Each
// byte is held in an input register while eight unrolled bit steps advance the
// parser state, and the result is registered on the master side from the byte
// that ends its record. A held result stalls the byte in the input register,
// and the slave side once that register is full. Bits left in a byte after a
// record ends are dropped; tuser on the slave side restarts parsing at that
// byte. Scale and skew are signed 15.16, translation is raw twips.
module affine_matrix_record_decoder import amrd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // data_byte
  input  logic [0:0]         s_axis_tuser,   // restart
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // scale_x, scale_y, skew_first,
                                             // skew_second, shift_x, shift_y
  output logic [1:0]         m_axis_tuser    // scale_present, skew_present
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_restart_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  logic       advance;
  logic       done;
  result_t    res;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser[0];
    end
    if (advance && done) begin
      out_q <= res;
    end
  end

  amrd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .byte_i    (in_byte_q),
    .restart_i (in_restart_q),
    .done_o    (done),
    .res_o     (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(TDATA_W - NUM_TERMS * TERM_W)'(0), out_q.terms};
  assign m_axis_tuser  = out_q.present;

  a_scale_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.present[0] |->
      out_q.terms[0] == ONE_FIXED && out_q.terms[1] == ONE_FIXED)
    else $error("absent scale not reported as one");

  a_skew_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.present[1] |->
      out_q.terms[2] == '0 && out_q.terms[3] == '0)
    else $error("absent skew not reported as zero");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |=>
      in_valid_q && $stable(in_byte_q) && $stable(in_restart_q))
    else $error("buffered byte lost while output stalled");

endmodule

>>> verif/tb_affine_matrix_record_decoder.sv
// ----------------------------------------------------------------------------
// tb_affine_matrix_record_decoder
// Self-checking bench for the transform record decoder.
// ----------------------------------------------------------------------------
// Encodes transform records into a byte stream and sends them with random
// gaps, while the result side stalls at random. A bit-serial model of the
// parser predicts each result that no directed row gives, and every result
// transfer is checked field by field. A short table of directed records comes
// first. It covers the identity record, translation extremes, one-bit and
// zero-width values, an abandoned record and restart. Random well-formed
// records follow, mixed with truncated records and noise bytes.
module tb_affine_matrix_record_decoder;

  timeunit 1ns;
  timeprecision 1ps;

  import amrd_pkg::*;

  localparam int RAND_ITEMS = 700;

  typedef struct packed {
    logic              kp;
    logic              sp;
    logic [TERM_W-1:0] ty;
    logic [TERM_W-1:0] tx;
    logic [TERM_W-1:0] r1;
    logic [TERM_W-1:0] r0;
    logic [TERM_W-1:0] sy;
    logic [TERM_W-1:0] sx;
  } xform_t;

  typedef struct packed {
    logic                  has_s;
    logic [WIDTH_BITS-1:0] sn;
    logic [TERM_W-1:0]     sx;
    logic [TERM_W-1:0]     sy;
    logic                  has_r;
    logic [WIDTH_BITS-1:0] rn;
    logic [TERM_W-1:0]     r0;
    logic [TERM_W-1:0]     r1;
    logic [WIDTH_BITS-1:0] tn;
    logic [TERM_W-1:0]     tx;
    logic [TERM_W-1:0]     ty;
  } rec_t;

  typedef struct packed {
    logic       r;
    logic [7:0] b;
  } stim_t;

  typedef struct packed {
    bit     restart;
    int     drop;     // bytes cut off the end, record abandoned
    rec_t   rc;
    bit     typed;    // want holds the expected result
    xform_t want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic [0:0]         s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [1:0]         m_axis_tuser;

  // parser model state
  phase_e                dec_phase;
  logic [WIDTH_BITS-1:0] dec_fbits;
  logic [WIDTH_BITS-1:0] dec_left;
  logic [31:0]           dec_acc;
  logic [TERM_W-1:0]     dec_terms [NUM_TERMS];
  logic [1:0]            dec_present;

  xform_t pending_xforms [$];
  stim_t  stim_q [$];
  bit     rec_bits [$];
  int     mismatches;
  int     bytes_sent;
  bit     feed_calm;
  bit     sink_calm;

  dir_row_t dir_rows [6] = '{
    '{restart: 1'b0, drop: 0, rc: '{default: '0}, typed: 1'b1,
      want: '{sx: ONE_FIXED, sy: ONE_FIXED, default: '0}},
    '{restart: 1'b0, drop: 0,
      rc: '{tn: 5'd31, tx: 31'h4000_0000, ty: 31'h3FFF_FFFF, default: '0},
      typed: 1'b1,
      want: '{sx: ONE_FIXED, sy: ONE_FIXED, tx: 31'h4000_0000, ty: 31'h3FFF_FFFF,
              default: '0}},
    '{restart: 1'b0, drop: 0,
      rc: '{has_s: 1'b1, sn: 5'd1, sx: 31'd1, tn: 5'd1, tx: 31'd1, default: '0},
      typed: 1'b1,
      want: '{sx: 31'h7FFF_FFFF, tx: 31'h7FFF_FFFF, sp: 1'b1, default: '0}},
    '{restart: 1'b1, drop: 0, rc: '{has_s: 1'b1, has_r: 1'b1, default: '0},
      typed: 1'b1, want: '{sp: 1'b1, kp: 1'b1, default: '0}},
    '{restart: 1'b0, drop: 7,
      rc: '{has_s: 1'b1, sn: 5'd31, sx: 31'h7FFF_FFFF, sy: 31'h5555_5555,
            default: '0},
      typed: 1'b0, want: '0},
    '{restart: 1'b1, drop: 0,
      rc: '{has_r: 1'b1, rn: 5'd16, r0: 31'h8000, r1: 31'h7FFF, tn: 5'd8,
            tx: 31'h80, ty: 31'h7F, default: '0},
      typed: 1'b0, want: '0}
  };

  affine_matrix_record_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic int term_slot(phase_e p);
    case (p)
      PH_SY:   return 1;
      PH_R0:   return 2;
      PH_R1:   return 3;
      PH_TX:   return 4;
      PH_TY:   return 5;
      default: return 0;
    endcase
  endfunction

  // zero-width values are taken on entry; returns 1 when the record is done
  function automatic bit enter_phase(phase_e p);
    while (1'b1) begin
      dec_phase = p;
      dec_acc   = '0;
      case (p)
        PH_DONE: return 1'b1;
        PH_SFLAG, PH_RFLAG: begin
          dec_left = WIDTH_BITS'(1);
          return 1'b0;
        end
        PH_SN, PH_RN, PH_TN: begin
          dec_left = WIDTH_BITS'(WIDTH_BITS);
          return 1'b0;
        end
        default: begin
          if (dec_fbits != '0) begin
            dec_left = dec_fbits;
            return 1'b0;
          end
          dec_terms[term_slot(p)] = '0;
          p = phase_e'(p << 1);
        end
      endcase
    end
    return 1'b1;
  endfunction

  function automatic void start_record();
    dec_terms[0] = ONE_FIXED;
    dec_terms[1] = ONE_FIXED;
    for (int k = 2; k < NUM_TERMS; k++) dec_terms[k] = '0;
    dec_present = '0;
    dec_fbits   = '0;
    void'(enter_phase(PH_SFLAG));
  endfunction

  function automatic bit take_bit(logic b);
    logic [TERM_W-1:0] v;
    dec_acc  = {dec_acc[30:0], b};
    dec_left = dec_left - WIDTH_BITS'(1);
    if (dec_left != '0) return 1'b0;
    case (dec_phase)
      PH_SFLAG: begin
        if (dec_acc[0]) begin
          dec_present[0] = 1'b1;
          return enter_phase(PH_SN);
        end
        return enter_phase(PH_RFLAG);
      end
      PH_RFLAG: begin
        if (dec_acc[0]) begin
          dec_present[1] = 1'b1;
          return enter_phase(PH_RN);
        end
        return enter_phase(PH_TN);
      end
      PH_SN, PH_RN, PH_TN: begin
        dec_fbits = dec_acc[WIDTH_BITS-1:0];
        return enter_phase(phase_e'(dec_phase << 1));
      end
      default: begin
        v = dec_acc[TERM_W-1:0];
        if (dec_acc[dec_fbits - 1]) v = v | ({TERM_W{1'b1}} << dec_fbits);
        dec_terms[term_slot(dec_phase)] = v;
        return enter_phase(phase_e'(dec_phase << 1));
      end
    endcase
  endfunction

  function automatic bit decode_byte(logic [7:0] b, logic r, output xform_t res);
    res = '0;
    if (r) start_record();
    for (int i = 7; i >= 0; i--) begin
      if (take_bit(b[i])) begin
        res.sx = dec_terms[0];
        res.sy = dec_terms[1];
        res.r0 = dec_terms[2];
        res.r1 = dec_terms[3];
        res.tx = dec_terms[4];
        res.ty = dec_terms[5];
        res.sp = dec_present[0];
        res.kp = dec_present[1];
        start_record();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void put_bits(logic [TERM_W-1:0] v, int n);
    for (int i = n - 1; i >= 0; i--) rec_bits.push_back(v[i]);
  endfunction

  // msb-first packing, random padding after the last field
  function automatic void encode_record(rec_t rc, bit restart_first);
    stim_t st;
    int    nbytes;
    rec_bits.delete();
    put_bits(TERM_W'(rc.has_s), 1);
    if (rc.has_s) begin
      put_bits(TERM_W'(rc.sn), WIDTH_BITS);
      put_bits(rc.sx, int'(rc.sn));
      put_bits(rc.sy, int'(rc.sn));
    end
    put_bits(TERM_W'(rc.has_r), 1);
    if (rc.has_r) begin
      put_bits(TERM_W'(rc.rn), WIDTH_BITS);
      put_bits(rc.r0, int'(rc.rn));
      put_bits(rc.r1, int'(rc.rn));
    end
    put_bits(TERM_W'(rc.tn), WIDTH_BITS);
    put_bits(rc.tx, int'(rc.tn));
    put_bits(rc.ty, int'(rc.tn));
    while (rec_bits.size() % 8 != 0) rec_bits.push_back(1'($urandom_range(0, 1)));
    nbytes = rec_bits.size() / 8;
    for (int k = 0; k < nbytes; k++) begin
      for (int j = 0; j < 8; j++) st.b[7 - j] = rec_bits[8 * k + j];
      st.r = restart_first && (k == 0);
      stim_q.push_back(st);
    end
  endfunction

  function automatic logic [WIDTH_BITS-1:0] rand_width();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 5'd31;
      2, 3, 4: return WIDTH_BITS'($urandom_range(1, 6));
      default: return WIDTH_BITS'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [TERM_W-1:0] rand_val(logic [WIDTH_BITS-1:0] n);
    if (n == '0) return TERM_W'($urandom);
    case ($urandom_range(0, 5))
      0:       return TERM_W'(1) << (n - 1);
      1:       return (TERM_W'(1) << (n - 1)) - TERM_W'(1);
      2:       return '1;
      default: return TERM_W'($urandom);
    endcase
  endfunction

  function automatic rec_t rand_record();
    rec_t rc;
    rc.has_s = 1'($urandom_range(0, 1));
    rc.sn    = rand_width();
    rc.sx    = rand_val(rc.sn);
    rc.sy    = rand_val(rc.sn);
    rc.has_r = 1'($urandom_range(0, 1));
    rc.rn    = rand_width();
    rc.r0    = rand_val(rc.rn);
    rc.r1    = rand_val(rc.rn);
    rc.tn    = rand_width();
    rc.tx    = rand_val(rc.tn);
    rc.ty    = rand_val(rc.tn);
    return rc;
  endfunction

  task automatic send_byte(stim_t st, bit typed, xform_t want);
    int     gap;
    xform_t pred;
    if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
    gap = feed_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= st.b;
    s_axis_tuser  <= st.r;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (decode_byte(st.b, st.r, pred)) pending_xforms.push_back(typed ? want : pred);
  endtask

  task automatic flush_stim(bit typed, xform_t want);
    while (stim_q.size() > 0) send_byte(stim_q.pop_front(), typed, want);
  endtask

  task automatic check_term(string name, logic [TERM_W-1:0] exp_v,
                            logic [TERM_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s: expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_xform();
    xform_t got;
    xform_t exp_x;
    got = {m_axis_tuser, m_axis_tdata[NUM_TERMS*TERM_W-1:0]};
    if (pending_xforms.size() == 0) begin
      $display("%0t unexpected transfer: expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      exp_x = pending_xforms.pop_front();
      check_term("scale_x", exp_x.sx, got.sx);
      check_term("scale_y", exp_x.sy, got.sy);
      check_term("skew_first", exp_x.r0, got.r0);
      check_term("skew_second", exp_x.r1, got.r1);
      check_term("shift_x", exp_x.tx, got.tx);
      check_term("shift_y", exp_x.ty, got.ty);
      check_term("scale_present", TERM_W'(exp_x.sp), TERM_W'(got.sp));
      check_term("skew_present", TERM_W'(exp_x.kp), TERM_W'(got.kp));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : sink
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_xform();
    end
  end

  initial begin : feed
    rec_t rc;
    bit   force_restart;
    int   pick;
    int   rand_start;
    int   cut;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    mismatches    = 0;
    bytes_sent    = 0;
    feed_calm     = 1'b0;
    sink_calm     = 1'b0;
    force_restart = 1'b0;
    start_record();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      encode_record(dir_rows[i].rc, dir_rows[i].restart);
      repeat (dir_rows[i].drop) void'(stim_q.pop_back());
      flush_stim(dir_rows[i].typed, dir_rows[i].want);
    end

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      rc   = rand_record();
      if (pick < 15) begin
        encode_record(rc, force_restart || ($urandom_range(0, 3) == 0));
        force_restart = 1'b0;
      end else if (pick < 17) begin
        // truncated record; the next record restarts unless noise bytes come between
        encode_record(rc, force_restart);
        if (stim_q.size() > 1) begin
          cut = $urandom_range(1, stim_q.size() - 1);
          repeat (cut) void'(stim_q.pop_back());
        end
        force_restart = 1'b1;
      end else begin
        repeat ($urandom_range(1, 4))
          stim_q.push_back('{r: ($urandom_range(0, 7) == 0), b: 8'($urandom)});
        force_restart = 1'($urandom_range(0, 1));
      end
      flush_stim(1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_xforms.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("affine_matrix_record_decoder: match");
    end else begin
      $display("affine_matrix_record_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("affine_matrix_record_decoder: mismatch");
    $finish;
  end

endmodule
